>>> sv/tmr8_pkg.sv
package tmr8_pkg;

    typedef enum logic [1:0]
    {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_ACK   = 2'd3
    } kind_t;

    typedef enum logic [1:0]
    {
        ACK_OVF  = 2'd0,
        ACK_CMPA = 2'd1,
        ACK_CMPB = 2'd2
    } ack_src_t;

    typedef enum logic [1:0]
    {
        CFG_OVF_IE  = 2'd0,
        CFG_CMPA_IE = 2'd1,
        CFG_CMPB_IE = 2'd2
    } cfg_index_t;

    localparam logic [7:0] ADDR_CTRL_A = 8'h44;
    localparam logic [7:0] ADDR_CTRL_B = 8'h45;
    localparam logic [7:0] ADDR_COUNT  = 8'h46;
    localparam logic [7:0] ADDR_CMP_A  = 8'h47;
    localparam logic [7:0] ADDR_CMP_B  = 8'h48;

    localparam logic [7:0] CTRL_A_MASK = 8'hF3;
    localparam logic [7:0] CTRL_B_MASK = 8'hCF;

    localparam logic [2:0] SEL_OFF     = 3'd0;
    localparam logic [2:0] SEL_DIV1    = 3'd1;
    localparam logic [2:0] SEL_DIV8    = 3'd2;
    localparam logic [2:0] SEL_DIV64   = 3'd3;
    localparam logic [2:0] SEL_DIV256  = 3'd4;
    localparam logic [2:0] SEL_DIV1024 = 3'd5;

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_CTC    = 3'd2;

    localparam int PRESCALE_W = 11;

    localparam int FLAG_OVF  = 0;
    localparam int FLAG_CMPA = 1;
    localparam int FLAG_CMPB = 2;

    typedef struct packed
    {
        logic cmpb;
        logic cmpa;
        logic ovf;
    } irq_en_t;

    typedef struct packed
    {
        logic       irq_compare_b;
        logic       irq_compare_a;
        logic       irq_overflow;
        logic [7:0] read_data;
    } result_t;

    function automatic logic [PRESCALE_W-1:0] divisor_of(input logic [2:0] sel);
        logic [PRESCALE_W-1:0] d;
        case (sel)
            SEL_DIV1:    d = PRESCALE_W'(1);
            SEL_DIV8:    d = PRESCALE_W'(8);
            SEL_DIV64:   d = PRESCALE_W'(64);
            SEL_DIV256:  d = PRESCALE_W'(256);
            SEL_DIV1024: d = PRESCALE_W'(1024);
            default:     d = '0;
        endcase
        return d;
    endfunction

endpackage

>>> sv/tmr8_core.sv
module tmr8_core
    import tmr8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       word_en,
    input  kind_t      kind,
    input  logic [7:0] reg_address,
    input  logic [7:0] write_data,
    input  logic       global_irq_enable,
    input  logic [1:0] ack_source,
    input  irq_en_t    irq_en,
    output result_t    result
);

    logic [7:0]            ctrl_a_reg, ctrl_a_next;
    logic [7:0]            ctrl_b_reg, ctrl_b_next;
    logic [7:0]            count_reg, count_next;
    logic [7:0]            cmp_a_reg, cmp_a_next;
    logic [7:0]            cmp_b_reg, cmp_b_next;
    logic [PRESCALE_W-1:0] pre_reg, pre_next;
    logic [2:0]            flags_reg, flags_next;

    logic [2:0]            sel;
    logic [2:0]            mode;
    logic [PRESCALE_W-1:0] pre_dec;
    logic [7:0]            count_inc;
    logic                  step;

    assign sel       = ctrl_b_reg[2:0];
    assign mode      = {ctrl_b_reg[3], ctrl_a_reg[1:0]};
    assign pre_dec   = (pre_reg != '0) ? pre_reg - PRESCALE_W'(1) : pre_reg;
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        ctrl_a_next = ctrl_a_reg;
        ctrl_b_next = ctrl_b_reg;
        count_next  = count_reg;
        cmp_a_next  = cmp_a_reg;
        cmp_b_next  = cmp_b_reg;
        pre_next    = pre_reg;
        flags_next  = flags_reg;
        step        = 1'b0;
        result      = '0;

        case (kind)
            KIND_TICK:
            begin
                if (sel != SEL_OFF)
                begin
                    if (sel <= SEL_DIV1024)
                    begin
                        pre_next = pre_dec;
                        if (pre_dec == '0)
                        begin
                            pre_next = divisor_of(sel);
                            step     = 1'b1;
                        end
                    end
                    if (step && (mode == MODE_NORMAL || mode == MODE_CTC))
                    begin
                        count_next = count_inc;
                        if (count_inc == 8'd0)
                        begin
                            flags_next[FLAG_OVF] = 1'b1;
                        end
                        else if (mode == MODE_CTC && count_inc == cmp_a_reg)
                        begin
                            flags_next[FLAG_CMPA] = 1'b1;
                            count_next            = 8'd0;
                        end
                    end
                    if (global_irq_enable)
                    begin
                        result.irq_overflow  = flags_next[FLAG_OVF] & irq_en.ovf;
                        result.irq_compare_a = flags_next[FLAG_CMPA] & irq_en.cmpa;
                        result.irq_compare_b = flags_next[FLAG_CMPB] & irq_en.cmpb;
                    end
                end
            end
            KIND_WRITE:
            begin
                case (reg_address)
                    ADDR_CTRL_A: ctrl_a_next = write_data & CTRL_A_MASK;
                    ADDR_CTRL_B: ctrl_b_next = write_data & CTRL_B_MASK;
                    ADDR_COUNT:  count_next  = write_data;
                    ADDR_CMP_A:  cmp_a_next  = write_data;
                    ADDR_CMP_B:  cmp_b_next  = write_data;
                    default:     ;
                endcase
            end
            KIND_READ:
            begin
                case (reg_address)
                    ADDR_CTRL_A: result.read_data = ctrl_a_reg;
                    ADDR_CTRL_B: result.read_data = ctrl_b_reg;
                    ADDR_COUNT:  result.read_data = count_reg;
                    ADDR_CMP_A:  result.read_data = cmp_a_reg;
                    ADDR_CMP_B:  result.read_data = cmp_b_reg;
                    default:     result.read_data = 8'd0;
                endcase
            end
            KIND_ACK:
            begin
                case (ack_source)
                    ACK_OVF:  flags_next[FLAG_OVF]  = 1'b0;
                    ACK_CMPA: flags_next[FLAG_CMPA] = 1'b0;
                    ACK_CMPB: flags_next[FLAG_CMPB] = 1'b0;
                    default:  ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
            count_reg  <= '0;
            cmp_a_reg  <= '0;
            cmp_b_reg  <= '0;
            pre_reg    <= '0;
            flags_reg  <= '0;
        end
        else if (word_en)
        begin
            ctrl_a_reg <= ctrl_a_next;
            ctrl_b_reg <= ctrl_b_next;
            count_reg  <= count_next;
            cmp_a_reg  <= cmp_a_next;
            cmp_b_reg  <= cmp_b_next;
            pre_reg    <= pre_next;
            flags_reg  <= flags_next;
        end
    end

endmodule

>>> sv/timer8_prescaled_ctc_counter_top.sv
// A result word is registered and is valid the cycle after its input word is taken.
// Throughput: one word per cycle; the single output register stalls input only
// while a held result is not taken.
// Reset (rst_n, async, active low) clears all timer registers, the prescaler,
// pending flags, interrupt enables and the output valid.
module timer8_prescaled_ctc_counter_top
    import tmr8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // reg_address[7:0], write_data[15:8],
                                       // global_irq_enable[16], ack_source[18:17]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // read_data[7:0], irq_overflow[8],
                                       // irq_compare_a[9], irq_compare_b[10]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_wdata
);

    irq_en_t irq_en_reg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    word_en;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign word_en       = s_axis_tvalid && s_axis_tready;

    tmr8_core u_core
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .word_en           (word_en),
        .kind              (kind_t'(s_axis_tuser)),
        .reg_address       (s_axis_tdata[7:0]),
        .write_data        (s_axis_tdata[15:8]),
        .global_irq_enable (s_axis_tdata[16]),
        .ack_source        (s_axis_tdata[18:17]),
        .irq_en            (irq_en_reg),
        .result            (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_en_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OVF_IE:  irq_en_reg.ovf  <= cfg_wdata;
                CFG_CMPA_IE: irq_en_reg.cmpa <= cfg_wdata;
                CFG_CMPB_IE: irq_en_reg.cmpb <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_en)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg};

endmodule

>>> sv/tmr8_checker.sv
module tmr8_checker
    import tmr8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata
);

    logic s_accept;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    // held result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // input stalls only behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a blocked result");

    // every accepted non-tick word yields a result next cycle and raises no irq
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_axis_tuser != KIND_TICK |=> m_axis_tvalid && m_axis_tdata[10:8] == 3'd0)
        else $error("irq candidate on a non-tick word");

    // only reads return data; ticks with global enable off raise nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_axis_tuser != KIND_READ && !s_axis_tdata[16]
            |=> m_axis_tdata[10:0] == 11'd0)
        else $error("non-read word without global enable returned nonzero");

endmodule

bind timer8_prescaled_ctc_counter_top tmr8_checker u_tmr8_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
